/* rtl/itoa_pkg.sv */
package itoa_pkg;

  localparam int unsigned MaxWidth  = 63;
  localparam int unsigned BinW      = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);
  localparam int unsigned StepW     = $clog2(BinW);
  localparam int unsigned WidthW    = 6;

  localparam logic [1:0] SizeW16 = 2'd0;
  localparam logic [1:0] SizeW32 = 2'd1;

  localparam logic [1:0] ConvSdec = 2'd0;
  localparam logic [1:0] ConvUdec = 2'd1;
  localparam logic [1:0] ConvHexL = 2'd2;
  localparam logic [1:0] ConvHexU = 2'd3;

  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] CharMinus   = 8'd45;
  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] LetterUpper = 8'd55;
  localparam logic [7:0] LetterLower = 8'd87;
  localparam logic [3:0] DigitNine   = 4'd9;

  typedef struct packed {
    logic [63:0]       value;
    logic [1:0]        operand_size;
    logic [1:0]        conversion;
    logic [WidthW-1:0] min_width;
    logic              zero_pad;
  } itoa_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } itoa_out_t;

  typedef enum logic [1:0] {
    SelSpace = 2'd0,
    SelMinus = 2'd1,
    SelZero  = 2'd2,
    SelDigit = 2'd3
  } emit_sel_e;

  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      strip_step;
    logic      calc_pad;
    logic      pad_step;
    logic      emit;
    emit_sel_e sel;
    logic      last;
  } itoa_cmd_t;

  typedef struct packed {
    logic hex;
    logic conv_last;
    logic strip_done;
    logic calc_none;
    logic pad_none;
    logic pad_one;
    logic neg;
    logic zpad;
    logic dig_last;
  } itoa_status_t;

endpackage

/* rtl/itoa_ctrl.sv */
module itoa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  itoa_pkg::itoa_status_t status_i,
  output itoa_pkg::itoa_cmd_t    cmd_o
);
  import itoa_pkg::*;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StConv   = 8'b0000_0010,
    StStrip  = 8'b0000_0100,
    StCalc   = 8'b0000_1000,
    StPadSp  = 8'b0001_0000,
    StSign   = 8'b0010_0000,
    StPadZr  = 8'b0100_0000,
    StDigits = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = SelDigit;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        // hex digits are already in place: skip the shift-add pass
        if (status_i.hex) begin
          state_d = StStrip;
        end else begin
          cmd_o.conv_step = 1'b1;
          if (status_i.conv_last) state_d = StStrip;
        end
      end
      StStrip: begin
        if (status_i.strip_done) state_d = StCalc;
        else cmd_o.strip_step = 1'b1;
      end
      StCalc: begin
        cmd_o.calc_pad = 1'b1;
        priority if (!status_i.zpad && !status_i.calc_none) state_d = StPadSp;
        else if (status_i.neg) state_d = StSign;
        else if (!status_i.calc_none) state_d = StPadZr;
        else state_d = StDigits;
      end
      StPadSp: begin
        cmd_o.emit     = 1'b1;
        cmd_o.sel      = SelSpace;
        cmd_o.pad_step = 1'b1;
        if (status_i.pad_one) state_d = status_i.neg ? StSign : StDigits;
      end
      StSign: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SelMinus;
        state_d    = status_i.pad_none ? StDigits : StPadZr;
      end
      StPadZr: begin
        cmd_o.emit     = 1'b1;
        cmd_o.sel      = SelZero;
        cmd_o.pad_step = 1'b1;
        if (status_i.pad_one) state_d = StDigits;
      end
      StDigits: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SelDigit;
        cmd_o.last = status_i.dig_last;
        if (status_i.dig_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/itoa_dp.sv */
module itoa_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  itoa_pkg::itoa_in_t     in_i,
  input  itoa_pkg::itoa_cmd_t    cmd_i,
  output itoa_pkg::itoa_status_t status_o,
  output itoa_pkg::itoa_out_t    result_o,
  output logic                   result_strobe_o
);
  import itoa_pkg::*;

  logic [BinW-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [DigCntW-1:0] ndig_q, ndig_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [WidthW-1:0]  pad_q, pad_d;
  logic [WidthW-1:0]  width_q, width_d;
  logic               neg_q, neg_d;
  logic               zpad_q, zpad_d;
  logic               padded_q, padded_d;
  logic               hex_q, hex_d;
  logic               upper_q, upper_d;
  itoa_out_t          res_q, res_d;
  logic               strobe_q, strobe_d;

  logic [BinW-1:0]    vm, mask, negv, mag;
  logic               sign_bit, neg_in;
  logic [BcdW-1:0]    bcd_adj;
  logic [WidthW-1:0]  textlen, calc_pad;
  logic [3:0]         top_dig;
  logic [7:0]         dig_char;

  // operand masking and magnitude
  always_comb begin
    unique case (in_i.operand_size)
      SizeW16: begin
        mask     = {{(BinW-16){1'b0}}, {16{1'b1}}};
        sign_bit = in_i.value[15];
      end
      SizeW32: begin
        mask     = {{(BinW-32){1'b0}}, {32{1'b1}}};
        sign_bit = in_i.value[31];
      end
      default: begin
        mask     = {BinW{1'b1}};
        sign_bit = in_i.value[BinW-1];
      end
    endcase
    vm     = in_i.value & mask;
    neg_in = (in_i.conversion == ConvSdec) && sign_bit;
    negv   = (~vm + {{(BinW-1){1'b0}}, 1'b1}) & mask;
    mag    = neg_in ? negv : vm;
  end

  // add three to each decimal digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] > 4'd4) ? bcd_q[4*i +: 4] + 4'd3
                                                   : bcd_q[4*i +: 4];
    end
  end

  assign top_dig  = bcd_q[BcdW-1 -: 4];
  assign dig_char = (top_dig > DigitNine) ? {4'd0, top_dig} + (upper_q ? LetterUpper : LetterLower)
                                          : {4'd0, top_dig} + CharZero;

  assign textlen  = WidthW'(ndig_q) + WidthW'(neg_q);
  assign calc_pad = (padded_q && (width_q > textlen)) ? width_q - textlen : '0;

  always_comb begin
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    ndig_d   = ndig_q;
    step_d   = step_q;
    pad_d    = pad_q;
    width_d  = width_q;
    neg_d    = neg_q;
    zpad_d   = zpad_q;
    padded_d = padded_q;
    hex_d    = hex_q;
    upper_d  = upper_q;
    res_d    = res_q;
    strobe_d = cmd_i.emit;

    if (cmd_i.load) begin
      bin_d    = mag;
      hex_d    = (in_i.conversion == ConvHexL) || (in_i.conversion == ConvHexU);
      bcd_d    = hex_d ? {{(BcdW-BinW){1'b0}}, mag} : '0;
      ndig_d   = DigCntW'(NumDigits);
      step_d   = StepW'(BinW - 1);
      width_d  = (in_i.min_width > WidthW'(MaxWidth)) ? WidthW'(MaxWidth) : in_i.min_width;
      neg_d    = neg_in;
      zpad_d   = in_i.zero_pad;
      padded_d = (in_i.operand_size == SizeW16) || (in_i.operand_size == SizeW32);
      upper_d  = (in_i.conversion == ConvHexU);
      pad_d    = '0;
    end

    if (cmd_i.conv_step) begin
      bcd_d  = {bcd_adj[BcdW-2:0], bin_q[BinW-1]};
      bin_d  = {bin_q[BinW-2:0], 1'b0};
      step_d = step_q - StepW'(1);
    end

    // drop a leading zero digit
    if (cmd_i.strip_step) begin
      bcd_d  = {bcd_q[BcdW-5:0], 4'd0};
      ndig_d = ndig_q - DigCntW'(1);
    end

    if (cmd_i.calc_pad) pad_d = calc_pad;
    if (cmd_i.pad_step) pad_d = pad_q - WidthW'(1);

    if (cmd_i.emit) begin
      res_d.last = cmd_i.last;
      unique case (cmd_i.sel)
        SelSpace: res_d.character = CharSpace;
        SelMinus: res_d.character = CharMinus;
        SelZero:  res_d.character = CharZero;
        SelDigit: begin
          res_d.character = dig_char;
          bcd_d  = {bcd_q[BcdW-5:0], 4'd0};
          ndig_d = ndig_q - DigCntW'(1);
        end
        default: res_d.character = CharSpace;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q    <= bin_d;
    bcd_q    <= bcd_d;
    ndig_q   <= ndig_d;
    step_q   <= step_d;
    pad_q    <= pad_d;
    width_q  <= width_d;
    neg_q    <= neg_d;
    zpad_q   <= zpad_d;
    padded_q <= padded_d;
    hex_q    <= hex_d;
    upper_q  <= upper_d;
    res_q    <= res_d;
  end

  assign status_o.hex        = hex_q;
  assign status_o.conv_last  = (step_q == '0);
  assign status_o.strip_done = (top_dig != 4'd0) || (ndig_q == DigCntW'(1));
  assign status_o.calc_none  = (calc_pad == '0);
  assign status_o.pad_none   = (pad_q == '0);
  assign status_o.pad_one    = (pad_q == WidthW'(1));
  assign status_o.neg        = neg_q;
  assign status_o.zpad       = zpad_q;
  assign status_o.dig_last   = (ndig_q == DigCntW'(1));

  assign result_o        = res_q;
  assign result_strobe_o = strobe_q;

endmodule

/* rtl/integer_to_ascii_formatter_top.sv */
// Channel   Handshake                  Beat
// --------  -------------------------  -------------------------------
// input     start high, busy low       in_i    (value, size, kind, width, pad)
// result    result_strobe_o, 1 cycle   result_o (character, last)
//
// An item takes a load, the shift-add pass of the binary-to-BCD unit (skipped for hex), a
// pass that drops leading zero digits (up to 19 dropped) and a step to work out the
// padding, then one character per cycle; each beat is registered before it is shown.
// busy stays high from the accepting edge until the last character is issued.
// Reset clears the sequencer and the output strobe; data registers are not reset.
// Results are shown for one cycle each and cannot be held off.
module integer_to_ascii_formatter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  itoa_pkg::itoa_in_t  in_i,
  output itoa_pkg::itoa_out_t result_o,
  output logic                result_strobe_o
);
  import itoa_pkg::*;

  itoa_cmd_t    cmd;
  itoa_status_t status;

  itoa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  itoa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

`ifndef SYNTHESIS
  a_strobe_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy))
    else $error("result beat without an item in progress");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.last) |-> !busy)
    else $error("last beat issued while item still in progress");

  a_no_emit_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.conv_step |-> !cmd.emit && !result_strobe_o)
    else $error("character issued during conversion");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import itoa_pkg::*;

  localparam logic [1:0] SizeW64   = 2'd2;
  localparam logic [1:0] SizeSpare = 2'd3;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned TailCycles = 300;
  localparam int unsigned RandomItems = 196;

  class char_scoreboard;
    itoa_out_t   expected_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Work out the characters one accepted number should produce.
    function void note_number(itoa_in_t item);
      logic [63:0] mask;
      logic [63:0] v;
      logic [63:0] mag;
      logic [63:0] rem;
      logic [7:0]  digit_chars[$];
      logic [7:0]  text[$];
      logic [7:0]  letter_base;
      logic [3:0]  d;
      int unsigned bits;
      int unsigned text_len;
      int unsigned pad_count;
      bit          negative;
      bit          padded;
      bit          hex;
      itoa_out_t   beat;

      bits = (item.operand_size == SizeW16) ? 16 : (item.operand_size == SizeW32) ? 32 : 64;
      padded = (bits < 64);
      mask = padded ? ((64'd1 << bits) - 64'd1) : '1;
      v = item.value & mask;
      hex = (item.conversion == ConvHexL) || (item.conversion == ConvHexU);
      negative = (item.conversion == ConvSdec) && v[bits-1];
      // two's complement magnitude, so the most negative value keeps its size
      mag = negative ? ((~v + 64'd1) & mask) : v;
      letter_base = (item.conversion == ConvHexU) ? LetterUpper : LetterLower;

      do begin
        if (hex) begin
          d = mag[3:0];
          mag = mag >> 4;
        end else begin
          rem = mag % 64'd10;
          d = rem[3:0];
          mag = mag / 64'd10;
        end
        digit_chars.push_front(d > DigitNine ? letter_base + {4'd0, d} : CharZero + {4'd0, d});
      end while (mag != 64'd0);

      text_len = digit_chars.size() + (negative ? 1 : 0);
      pad_count = (padded && item.min_width > text_len) ? item.min_width - text_len : 0;

      if (!item.zero_pad)
        repeat (pad_count) text.push_back(CharSpace);
      if (negative)
        text.push_back(CharMinus);
      if (item.zero_pad)
        repeat (pad_count) text.push_back(CharZero);
      foreach (digit_chars[k])
        text.push_back(digit_chars[k]);

      foreach (text[k]) begin
        beat.character = text[k];
        beat.last = (k == text.size() - 1);
        expected_chars.push_back(beat);
      end
    endfunction

    function void check_char(itoa_out_t got);
      itoa_out_t want;

      if (expected_chars.size() == 0) begin
        $display("%0t: character beat with nothing pending: expected none, actual %h last %b",
                 $time, got.character, got.last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (got.character !== want.character) begin
        $display("%0t: character: expected %h, actual %h", $time, want.character,
                 got.character);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last: expected %b, actual %b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  itoa_in_t  in_i;
  itoa_out_t result_o;
  logic      result_strobe_o;

  char_scoreboard sb;
  bit             idle_on;
  int unsigned    stall_cycles;

  integer_to_ascii_formatter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_o       (result_o),
    .result_strobe_o(result_strobe_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Check and note at the rising edge; a watchdog ends a hung run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_strobe_o) sb.check_char(result_o);
      if (start && !busy) sb.note_number(in_i);
      if (result_strobe_o || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  function automatic itoa_in_t pack_number(logic [63:0] value, logic [1:0] size,
                                           logic [1:0] conv, logic [5:0] width, logic zpad);
    itoa_in_t item;
    item.value = value;
    item.operand_size = size;
    item.conversion = conv;
    item.min_width = width;
    item.zero_pad = zpad;
    return item;
  endfunction

  // Present one beat at the falling edge and hold it until it is taken.
  task automatic send_number(input itoa_in_t item);
    logic [95:0] noise;
    while (idle_on && $urandom_range(99) < 9) begin
      noise = {$urandom, $urandom, $urandom};
      start <= 1'b0;
      in_i <= noise[$bits(itoa_in_t)-1:0];
      @(negedge clk_i);
    end
    start <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.expected_chars.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    itoa_in_t    item;
    logic [63:0] mask;
    logic [63:0] sign_bit;
    logic [63:0] raw;
    logic [63:0] small_val;
    int unsigned bits;
    int unsigned pick;

    sb = new();
    stall_cycles = 0;
    idle_on = 1'b1;
    start = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // most negative values, all-ones operands and their padding
    send_number(pack_number(64'h0000_0000_0000_8000, SizeW16, ConvSdec, 6'd0, 1'b0));
    send_number(pack_number(64'hFFFF_FFFF_FFFF_8000, SizeW16, ConvSdec, 6'd10, 1'b1));
    send_number(pack_number(64'h0000_0000_0000_8000, SizeW16, ConvSdec, 6'd10, 1'b0));
    send_number(pack_number(64'h1234_5678_8000_0000, SizeW32, ConvSdec, 6'd12, 1'b1));
    send_number(pack_number(64'h8000_0000_0000_0000, SizeW64, ConvSdec, 6'd30, 1'b1));
    send_number(pack_number(64'hFFFF_FFFF_FFFF_FFFF, SizeW64, ConvSdec, 6'd40, 1'b0));
    send_number(pack_number(64'hFFFF_FFFF_FFFF_FFFF, SizeW64, ConvUdec, 6'd63, 1'b1));
    // zero, hex and full width
    send_number(pack_number(64'h0, SizeW16, ConvUdec, 6'd0, 1'b0));
    send_number(pack_number(64'hFFFF_FFFF_0000_0000, SizeW32, ConvHexL, 6'd63, 1'b1));
    send_number(pack_number(64'h0, SizeW16, ConvSdec, 6'd63, 1'b0));
    send_number(pack_number(64'hABCD_0123_DEAD_BEEF, SizeW32, ConvHexL, 6'd9, 1'b0));
    send_number(pack_number(64'hABCD_0123_DEAD_BEEF, SizeW32, ConvHexU, 6'd9, 1'b1));
    send_number(pack_number(64'hFFFF_FFFF_FFFF_FFFF, SizeW64, ConvHexU, 6'd63, 1'b0));
    send_number(pack_number(64'h0123_4567_89AB_CDEF, SizeW64, ConvHexL, 6'd0, 1'b1));
    // width below, at and above the text length
    send_number(pack_number(64'h5555_AAAA_1234_FFFF, SizeW16, ConvUdec, 6'd3, 1'b0));
    send_number(pack_number(64'h0000_0000_0000_3039, SizeW16, ConvUdec, 6'd5, 1'b1));
    send_number(pack_number(64'h0000_0000_0000_7FFF, SizeW16, ConvSdec, 6'd6, 1'b0));
    send_number(pack_number(64'hFFFF_FFFF_FFFF_FFFF, SizeW16, ConvSdec, 6'd63, 1'b0));
    send_number(pack_number(64'hFFFF_FFFF_FFFF_FFFF, SizeW16, ConvSdec, 6'd63, 1'b1));
    send_number(pack_number(64'h0000_0000_FFFF_FFFF, SizeW32, ConvUdec, 6'd63, 1'b1));
    send_number(pack_number(64'h0000_0000_7FFF_FFFF, SizeW32, ConvSdec, 6'd1, 1'b0));
    // spare size code behaves as a 64-bit operand
    send_number(pack_number(64'hFFFF_FFFF_FFFF_FF85, SizeSpare, ConvSdec, 6'd20, 1'b1));
    send_number(pack_number(64'h8000_0000_0000_0000, SizeSpare, ConvUdec, 6'd20, 1'b0));
    send_number(pack_number(64'h0000_0000_0000_00FF, SizeSpare, ConvHexU, 6'd0, 1'b0));
    wait_drained();

    for (int n = 0; n < RandomItems; n++) begin
      // long stretch with the sender never idling
      idle_on = !(n >= 80 && n < 140);
      if (n == 150) wait_drained();

      pick = $urandom_range(9);
      item.operand_size = (pick < 3) ? SizeW16 : (pick < 6) ? SizeW32 :
                          (pick < 9) ? SizeW64 : SizeSpare;
      item.conversion = 2'($urandom_range(3));
      item.zero_pad = 1'($urandom_range(1));
      item.min_width = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                : 6'($urandom_range(12));

      bits = (item.operand_size == SizeW16) ? 16 : (item.operand_size == SizeW32) ? 32 : 64;
      mask = (bits < 64) ? ((64'd1 << bits) - 64'd1) : '1;
      sign_bit = 64'd1 << (bits - 1);
      raw = {$urandom, $urandom};
      small_val = 64'($urandom_range(999));
      case ($urandom_range(4))
        0: item.value = (raw & ~mask) | small_val;
        1: item.value = (raw & ~mask) | ((64'd0 - small_val) & mask);
        2: item.value = (raw & ~mask) |
                        ((sign_bit + 64'($urandom_range(4)) - 64'd2) & mask);
        default: item.value = raw;
      endcase

      send_number(item);
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
